// ===== hdl/cgs_pkg.sv =====
`default_nettype none

package cgs_pkg;

   // Largest system handled; the cell row, the matrix memory and all index widths follow it.
   localparam int MAX_N = 16;
   localparam int IW = $clog2(MAX_N);
   localparam int NW = $clog2(MAX_N + 1);
   localparam int AW = $clog2(MAX_N * MAX_N);

   // Quotient bits produced by the divider: a 32-bit magnitude scaled by 2^16.
   localparam int DIV_STEPS = 48;

   typedef logic [IW-1:0] idx_type;
   typedef logic [NW-1:0] cnt_type;
   typedef logic [AW-1:0] addr_type;

   typedef logic signed [31:0] q_type;
   typedef logic signed [47:0] prod_type;
   typedef logic signed [63:0] wide_type;

   localparam q_type Q_MAX = 32'sh7FFFFFFF;
   localparam q_type Q_MIN = 32'sh80000000;
   localparam wide_type WIDE_MAX = 64'sd2147483647;
   localparam wide_type WIDE_MIN = -64'sd2147483648;

   // Request kinds.
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_SIZE     = 2'd0;
   localparam logic [1:0] REG_MAX_ITER = 2'd1;
   localparam logic [1:0] REG_TOL      = 2'd2;

   typedef struct packed {
      logic x;
      logic r;
      logic p;
      logic z;
   } shift_type;

   typedef struct packed {
      logic      init;
      shift_type sh;
   } cell_ctl_type;

   typedef struct packed {
      q_type x;
      q_type r;
      q_type p;
      q_type z;
   } vec_type;

   typedef struct packed {
      logic  done;
      q_type quo;
   } div_rsp_type;

   function automatic q_type sat32(input wide_type v);
      if (v > WIDE_MAX) begin
         return Q_MAX;
      end else if (v < WIDE_MIN) begin
         return Q_MIN;
      end
      return q_type'(v);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/conjugate_gradient_solver.sv =====
`default_nettype none

// Dense conjugate-gradient solver for A x = b in signed Q16.16 with saturation. Each request
// beat either loads one matrix entry, loads one right-hand-side entry, or starts a solve
// from x = 0 over the leading N by N block. The vectors x, r, p and z live in a row of
// MAX_N cells that rotate one element per step past a single shared multiplier; every
// element passes through operand fetch, multiply, and accumulate or write back in turn.
// A full iteration is a matrix-vector product of MAX_N row passes, five vector passes and
// two divisions in the bit-serial divider. The matrix-vector product, bounded by the one
// multiplier and the single read port of the matrix memory, dominates. A start beat first
// sets r and p to b and forms r.r in a setup pass; when the solve ends, N response beats
// follow, one per solution element, carrying the last-element mark, the converged flag and
// the step count. No request is taken until the final response beat of a solve has been
// accepted.
module conjugate_gradient_solver (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [3:0]         req_row_index,
   input  logic [3:0]         req_col_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_element_index,
   output logic signed [31:0] rsp_solution_value,
   output logic               rsp_last_element,
   output logic               rsp_converged,
   output logic [15:0]        rsp_steps_used,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // Sequencer states. The pass states step through the cell row element by element.
   typedef enum logic [14:0] {
      ST_IDLE   = 15'h0001,
      ST_INIT   = 15'h0002,
      ST_GAMMA0 = 15'h0004,
      ST_CHECK  = 15'h0008,
      ST_MATVEC = 15'h0010,
      ST_ROWEND = 15'h0020,
      ST_DOTPZ  = 15'h0040,
      ST_DIVA   = 15'h0080,
      ST_UPDX   = 15'h0100,
      ST_UPDR   = 15'h0200,
      ST_DOTRR  = 15'h0400,
      ST_TEST   = 15'h0800,
      ST_DIVB   = 15'h1000,
      ST_UPDP   = 15'h2000,
      ST_OUT    = 15'h4000
   } state_type;

   // Element phases within a pass.
   localparam logic [1:0] PH_OPS = 2'd0;
   localparam logic [1:0] PH_MUL = 2'd1;
   localparam logic [1:0] PH_USE = 2'd2;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [4:0]  size_ff;
   logic [15:0] max_iter_ff;
   logic [30:0] tol_ff;

   // Sequencer counters and flags.
   cgs_pkg::cnt_type n_ff;
   cgs_pkg::idx_type elem_ff;
   cgs_pkg::idx_type row_ff;
   cgs_pkg::idx_type out_ff;
   logic [1:0]       phase_ff;
   logic [15:0]      steps_ff;
   logic             conv_ff;
   logic             go_ff;

   // Scalars and datapath registers.
   cgs_pkg::q_type    gamma_ff;
   cgs_pkg::q_type    gnew_ff;
   cgs_pkg::q_type    coef_ff;
   cgs_pkg::q_type    num_ff;
   cgs_pkg::q_type    den_ff;
   cgs_pkg::q_type    op_a_ff;
   cgs_pkg::q_type    op_b_ff;
   cgs_pkg::q_type    rd_ff;
   cgs_pkg::wide_type acc_ff;

   // The matrix, row-major, MAX_N entries per row.
   cgs_pkg::q_type mem [cgs_pkg::MAX_N * cgs_pkg::MAX_N];

   logic                 req_fire;
   logic                 out_fire;
   logic                 out_last;
   logic                 cfg_fire;
   logic                 in_pass;
   logic                 is_dot;
   logic                 ph_use;
   logic                 pass_last;
   logic                 active;
   logic                 below_tol;
   logic                 load_a;
   logic                 load_b;
   cgs_pkg::cnt_type     n_clamp;
   cgs_pkg::addr_type    wr_addr;
   cgs_pkg::addr_type    rd_addr;
   cgs_pkg::wide_type    acc_sum;
   cgs_pkg::q_type       dot_sat;
   cgs_pkg::q_type       sel_a;
   cgs_pkg::q_type       sel_b;
   cgs_pkg::q_type       mul_a;
   cgs_pkg::prod_type    prod;
   cgs_pkg::vec_type     head;
   cgs_pkg::vec_type     tail;
   cgs_pkg::cell_ctl_type cell_ctl;
   cgs_pkg::div_rsp_type div_rsp;
   cgs_pkg::vec_type     chain [cgs_pkg::MAX_N + 1];
   logic [cgs_pkg::MAX_N-1:0] ld_b;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_fire  = (state_ff == ST_OUT) && !rsp_stall;
   assign out_last  = (cgs_pkg::cnt_type'(out_ff) == n_ff - cgs_pkg::cnt_type'(1));
   assign cfg_fire  = csr_psel && csr_penable && csr_pwrite;

   assign load_a = req_fire && (req_kind == cgs_pkg::KIND_LOAD_A)
                   && (32'(req_row_index) < cgs_pkg::MAX_N)
                   && (32'(req_col_index) < cgs_pkg::MAX_N);
   assign load_b = req_fire && (req_kind == cgs_pkg::KIND_LOAD_B);

   // A size of zero acts as one; anything above the cell count acts as the cell count.
   always_comb begin
      if (size_ff == 5'd0) begin
         n_clamp = cgs_pkg::cnt_type'(1);
      end else if (32'(size_ff) > cgs_pkg::MAX_N) begin
         n_clamp = cgs_pkg::cnt_type'(cgs_pkg::MAX_N);
      end else begin
         n_clamp = cgs_pkg::cnt_type'(size_ff);
      end
   end

   assign in_pass = (state_ff == ST_GAMMA0) || (state_ff == ST_MATVEC)
                 || (state_ff == ST_DOTPZ)  || (state_ff == ST_UPDX)
                 || (state_ff == ST_UPDR)   || (state_ff == ST_DOTRR)
                 || (state_ff == ST_UPDP);
   assign is_dot  = (state_ff == ST_GAMMA0) || (state_ff == ST_MATVEC)
                 || (state_ff == ST_DOTPZ)  || (state_ff == ST_DOTRR);
   assign ph_use    = in_pass && (phase_ff == PH_USE);
   assign pass_last = ph_use && (elem_ff == cgs_pkg::idx_type'(cgs_pkg::MAX_N - 1));

   // Elements at or past N are left unchanged by the update passes and add nothing to any sum.
   assign active  = (cgs_pkg::cnt_type'(elem_ff) < n_ff);
   assign acc_sum = acc_ff + (active ? cgs_pkg::wide_type'(prod) : '0);
   assign dot_sat = cgs_pkg::sat32(acc_sum);

   assign below_tol = ($signed(gnew_ff) < $signed({1'b0, tol_ff}));

   assign wr_addr = cgs_pkg::addr_type'(req_row_index) * cgs_pkg::addr_type'(cgs_pkg::MAX_N)
                  + cgs_pkg::addr_type'(req_col_index);
   assign rd_addr = cgs_pkg::addr_type'(row_ff) * cgs_pkg::addr_type'(cgs_pkg::MAX_N)
                  + cgs_pkg::addr_type'(elem_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == cgs_pkg::KIND_START)) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT:   state_in = ST_GAMMA0;
         ST_GAMMA0: if (pass_last) state_in = ST_CHECK;
         ST_CHECK:  state_in = (steps_ff < max_iter_ff) ? ST_MATVEC : ST_OUT;
         ST_MATVEC: if (pass_last) state_in = ST_ROWEND;
         ST_ROWEND: begin
            state_in = (row_ff == cgs_pkg::idx_type'(cgs_pkg::MAX_N - 1)) ? ST_DOTPZ : ST_MATVEC;
         end
         ST_DOTPZ:  if (pass_last) state_in = ST_DIVA;
         ST_DIVA:   if (div_rsp.done) state_in = ST_UPDX;
         ST_UPDX:   if (pass_last) state_in = ST_UPDR;
         ST_UPDR:   if (pass_last) state_in = ST_DOTRR;
         ST_DOTRR:  if (pass_last) state_in = ST_TEST;
         ST_TEST:   state_in = below_tol ? ST_OUT : ST_DIVB;
         ST_DIVB:   if (div_rsp.done) state_in = ST_UPDP;
         ST_UPDP:   if (pass_last) state_in = ST_CHECK;
         ST_OUT:    if (out_fire && out_last) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Operand selection for the shared multiplier; vector operands come from the row head.
   always_comb begin
      sel_a = '0;
      sel_b = '0;
      unique case (state_ff)
         ST_GAMMA0, ST_DOTRR: begin
            sel_a = head.r;
            sel_b = head.r;
         end
         ST_MATVEC: begin
            sel_b = head.p;
         end
         ST_DOTPZ: begin
            sel_a = head.p;
            sel_b = head.z;
         end
         ST_UPDX, ST_UPDP: begin
            sel_a = coef_ff;
            sel_b = head.p;
         end
         ST_UPDR: begin
            sel_a = coef_ff;
            sel_b = head.z;
         end
         default: begin
            sel_a = '0;
            sel_b = '0;
         end
      endcase
   end

   // The matrix operand comes straight from the registered memory read.
   assign mul_a = (state_ff == ST_MATVEC) ? rd_ff : op_a_ff;

   // Value fed into the far end of the row. By default the head wraps around unchanged; the
   // update passes and the row-end step write the new element in its place.
   always_comb begin
      tail = head;
      if ((state_ff == ST_UPDX) && active) begin
         tail.x = cgs_pkg::sat32(cgs_pkg::wide_type'(head.x) + cgs_pkg::wide_type'(prod));
      end
      if ((state_ff == ST_UPDR) && active) begin
         tail.r = cgs_pkg::sat32(cgs_pkg::wide_type'(head.r) - cgs_pkg::wide_type'(prod));
      end
      if ((state_ff == ST_UPDP) && active) begin
         tail.p = cgs_pkg::sat32(cgs_pkg::wide_type'(head.r) + cgs_pkg::wide_type'(prod));
      end
      if (state_ff == ST_ROWEND) begin
         tail.z = cgs_pkg::sat32(acc_ff);
      end
   end

   // Which vectors rotate this cycle.
   always_comb begin
      cell_ctl.init = (state_ff == ST_INIT);
      cell_ctl.sh   = '0;
      if (ph_use) begin
         unique case (state_ff)
            ST_GAMMA0, ST_DOTRR: cell_ctl.sh.r = 1'b1;
            ST_MATVEC:           cell_ctl.sh.p = 1'b1;
            ST_DOTPZ: begin
               cell_ctl.sh.p = 1'b1;
               cell_ctl.sh.z = 1'b1;
            end
            ST_UPDX: begin
               cell_ctl.sh.x = 1'b1;
               cell_ctl.sh.p = 1'b1;
            end
            ST_UPDR: begin
               cell_ctl.sh.r = 1'b1;
               cell_ctl.sh.z = 1'b1;
            end
            ST_UPDP: begin
               cell_ctl.sh.r = 1'b1;
               cell_ctl.sh.p = 1'b1;
            end
            default: cell_ctl.sh = '0;
         endcase
      end
      if (state_ff == ST_ROWEND) begin
         cell_ctl.sh.z = 1'b1;
      end
      if (out_fire) begin
         cell_ctl.sh.x = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_OPS;
         elem_ff     <= '0;
         row_ff      <= '0;
         out_ff      <= '0;
         steps_ff    <= '0;
         conv_ff     <= 1'b0;
         go_ff       <= 1'b0;
         size_ff     <= 5'd16;
         max_iter_ff <= 16'd1000;
         tol_ff      <= 31'd1;
      end else begin
         state_ff <= state_in;
         go_ff    <= 1'b0;

         if (cfg_fire) begin
            unique case (csr_paddr[3:2])
               cgs_pkg::REG_SIZE:     size_ff     <= csr_pwdata[4:0];
               cgs_pkg::REG_MAX_ITER: max_iter_ff <= csr_pwdata[15:0];
               cgs_pkg::REG_TOL:      tol_ff      <= csr_pwdata[30:0];
               default: ;
            endcase
         end

         if (in_pass) begin
            unique case (phase_ff)
               PH_OPS:  phase_ff <= PH_MUL;
               PH_MUL:  phase_ff <= PH_USE;
               PH_USE:  phase_ff <= PH_OPS;
               default: phase_ff <= PH_OPS;
            endcase
            if (ph_use) begin
               elem_ff <= pass_last ? '0 : elem_ff + cgs_pkg::idx_type'(1);
            end
         end

         if (state_ff == ST_INIT) begin
            steps_ff <= '0;
            conv_ff  <= 1'b0;
            elem_ff  <= '0;
            phase_ff <= PH_OPS;
         end
         if (state_ff == ST_CHECK) begin
            row_ff <= '0;
         end
         if (state_ff == ST_ROWEND) begin
            row_ff <= row_ff + cgs_pkg::idx_type'(1);
         end
         if ((state_ff == ST_DOTPZ) && pass_last) begin
            go_ff <= 1'b1;
         end
         if ((state_ff == ST_DOTRR) && pass_last) begin
            steps_ff <= steps_ff + 16'd1;
         end
         if (state_ff == ST_TEST) begin
            if (below_tol) begin
               conv_ff <= 1'b1;
            end else begin
               go_ff <= 1'b1;
            end
         end

         if (state_ff != ST_OUT) begin
            out_ff <= '0;
         end else if (out_fire) begin
            out_ff <= out_ff + cgs_pkg::idx_type'(1);
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire && (req_kind == cgs_pkg::KIND_START)) begin
         n_ff <= n_clamp;
      end

      if (in_pass && (phase_ff == PH_OPS)) begin
         op_a_ff <= sel_a;
         op_b_ff <= sel_b;
      end

      // The accumulator starts each sum at zero.
      if ((state_ff == ST_INIT) || (state_ff == ST_ROWEND)) begin
         acc_ff <= '0;
      end else if (ph_use && is_dot) begin
         acc_ff <= (pass_last && (state_ff != ST_MATVEC)) ? '0 : acc_sum;
      end

      if ((state_ff == ST_GAMMA0) && pass_last) begin
         gamma_ff <= dot_sat;
      end
      if ((state_ff == ST_DOTPZ) && pass_last) begin
         num_ff <= gamma_ff;
         den_ff <= dot_sat;
      end
      if ((state_ff == ST_DOTRR) && pass_last) begin
         gnew_ff <= dot_sat;
      end
      if ((state_ff == ST_TEST) && !below_tol) begin
         num_ff <= gnew_ff;
         den_ff <= gamma_ff;
      end
      if ((state_ff == ST_UPDP) && pass_last) begin
         gamma_ff <= gnew_ff;
      end
      if (((state_ff == ST_DIVA) || (state_ff == ST_DIVB)) && div_rsp.done) begin
         coef_ff <= div_rsp.quo;
      end
   end

   // Matrix memory: one write port for loads, one registered read port for the product.
   always_ff @(posedge clock) begin
      if (load_a) begin
         mem[wr_addr] <= req_value;
      end
      rd_ff <= mem[rd_addr];
   end

   cgs_mul u_mul (
      .clock (clock),
      .en    (in_pass && (phase_ff == PH_MUL)),
      .op_a  (mul_a),
      .op_b  (op_b_ff),
      .prod  (prod)
   );

   cgs_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (go_ff),
      .num   (num_ff),
      .den   (den_ff),
      .rsp   (div_rsp)
   );

   // The cell row. Cell zero is the head; the tail value enters at the far end.
   assign chain[cgs_pkg::MAX_N] = tail;
   assign head = chain[0];

   for (genvar k = 0; k < cgs_pkg::MAX_N; k++) begin : g_cell
      assign ld_b[k] = load_b && (32'(req_row_index) == 32'(k));

      cgs_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .ld_b     (ld_b[k]),
         .b_in     (req_value),
         .nb_in    (chain[k + 1]),
         .cell_out (chain[k])
      );
   end

   // Response channel: the head of the x row is the element on offer.
   assign rsp_valid          = (state_ff == ST_OUT);
   assign rsp_element_index  = 4'(out_ff);
   assign rsp_solution_value = head.x;
   assign rsp_last_element   = out_last;
   assign rsp_converged      = conv_ff;
   assign rsp_steps_used     = steps_ff;

   // Register read back.
   always_comb begin
      unique case (csr_paddr[3:2])
         cgs_pkg::REG_SIZE:     csr_prdata = {27'd0, size_ff};
         cgs_pkg::REG_MAX_ITER: csr_prdata = {16'd0, max_iter_ff};
         cgs_pkg::REG_TOL:      csr_prdata = {1'b0, tol_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;

endmodule

`default_nettype wire

// ===== hdl/cgs_cell.sv =====
`default_nettype none

// One element of each solver vector. The row shifts toward cell zero.
module cgs_cell (
   input  logic                 clock,
   input  cgs_pkg::cell_ctl_type ctl,
   input  logic                 ld_b,
   input  cgs_pkg::q_type       b_in,
   input  cgs_pkg::vec_type     nb_in,
   output cgs_pkg::vec_type     cell_out
);

   cgs_pkg::q_type   b_ff;
   cgs_pkg::vec_type v_ff;

   always_ff @(posedge clock) begin
      if (ld_b) begin
         b_ff <= b_in;
      end
      if (ctl.init) begin
         v_ff.x <= '0;
         v_ff.r <= b_ff;
         v_ff.p <= b_ff;
      end else begin
         if (ctl.sh.x) begin
            v_ff.x <= nb_in.x;
         end
         if (ctl.sh.r) begin
            v_ff.r <= nb_in.r;
         end
         if (ctl.sh.p) begin
            v_ff.p <= nb_in.p;
         end
         if (ctl.sh.z) begin
            v_ff.z <= nb_in.z;
         end
      end
   end

   assign cell_out = v_ff;

endmodule

`default_nettype wire

// ===== hdl/cgs_mul.sv =====
`default_nettype none

// Q16.16 product, floored, registered.
module cgs_mul (
   input  logic              clock,
   input  logic              en,
   input  cgs_pkg::q_type    op_a,
   input  cgs_pkg::q_type    op_b,
   output cgs_pkg::prod_type prod
);

   cgs_pkg::wide_type full;
   cgs_pkg::prod_type prod_ff;

   assign full = op_a * op_b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= cgs_pkg::prod_type'(full >>> 16);
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hdl/cgs_div.sv =====
`default_nettype none

// Restoring divider on magnitudes: quotient = (num * 2^16) / den, one bit per cycle,
// truncated toward zero and saturated. A zero divisor is answered in the cycle after go.
module cgs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  cgs_pkg::q_type       num,
   input  cgs_pkg::q_type       den,
   output cgs_pkg::div_rsp_type rsp
);

   logic           busy_ff;
   logic           done_ff;
   logic           neg_ff;
   logic [5:0]     cnt_ff;
   logic [32:0]    rem_ff;
   logic [47:0]    dq_ff;
   logic [31:0]    dm_ff;
   cgs_pkg::q_type quo_ff;

   logic [31:0]    num_mag;
   logic [31:0]    den_mag;
   logic [32:0]    rem_sh;
   logic           fits;
   logic [32:0]    rem_in;
   logic [47:0]    q_fin;
   cgs_pkg::q_type q_sat;
   cgs_pkg::q_type q_zero;

   assign num_mag = num[31] ? (~num + 32'd1) : num;
   assign den_mag = den[31] ? (~den + 32'd1) : den;
   assign rem_sh  = {rem_ff[31:0], dq_ff[47]};
   assign fits    = rem_sh >= {1'b0, dm_ff};
   assign rem_in  = fits ? (rem_sh - {1'b0, dm_ff}) : rem_sh;
   assign q_fin   = {dq_ff[46:0], fits};

   always_comb begin
      if (neg_ff) begin
         q_sat = (q_fin > 48'h0000_8000_0000) ? cgs_pkg::Q_MIN
                                              : cgs_pkg::q_type'(32'd0 - q_fin[31:0]);
      end else begin
         q_sat = (q_fin > 48'h0000_7FFF_FFFF) ? cgs_pkg::Q_MAX : cgs_pkg::q_type'(q_fin[31:0]);
      end
      if (num > 0) begin
         q_zero = cgs_pkg::Q_MAX;
      end else if (num < 0) begin
         q_zero = cgs_pkg::Q_MIN;
      end else begin
         q_zero = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            if (den == 0) begin
               done_ff <= 1'b1;
               quo_ff  <= q_zero;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= '0;
               rem_ff  <= '0;
               dq_ff   <= {num_mag, 16'd0};
               dm_ff   <= den_mag;
               neg_ff  <= num[31] ^ den[31];
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dq_ff  <= q_fin;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(cgs_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quo_ff  <= q_sat;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/cgs_checker.sv =====
`default_nettype none

module cgs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [3:0]         rsp_element_index,
   input logic signed [31:0] rsp_solution_value,
   input logic               rsp_last_element,
   input logic               rsp_converged,
   input logic [15:0]        rsp_steps_used
);

   // No request is taken while a solution is being handed out.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted during solution output");

   // A stalled response beat holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_solution_value)
                                 && $stable(rsp_element_index))
      else $error("stalled response beat changed");

   // Elements follow one another without gaps.
   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_element |=>
         rsp_valid && (rsp_element_index == 4'($past(rsp_element_index) + 4'd1)))
      else $error("solution element skipped or stalled");

   // The stream ends with the last element.
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_element |=> !rsp_valid)
      else $error("response after last element");

   // Convergence is only reported after at least one iteration.
   a_conv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_converged |-> rsp_steps_used != 16'd0)
      else $error("converged with zero steps");

endmodule

bind conjugate_gradient_solver cgs_checker u_cgs_checker (.*);

`default_nettype wire

// ===== tb/tb_conjugate_gradient_solver.sv =====
`timescale 1ns / 100ps

module tb_conjugate_gradient_solver;

   // The one request code that the package leaves unnamed; the block must drop it.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = cgs_pkg::KIND_LOAD_A;
   logic [3:0]         req_row_index = '0;
   logic [3:0]         req_col_index = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_element_index;
   logic signed [31:0] rsp_solution_value;
   logic               rsp_last_element;
   logic               rsp_converged;
   logic [15:0]        rsp_steps_used;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   conjugate_gradient_solver u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_row_index(req_row_index), .req_col_index(req_col_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_element_index(rsp_element_index), .rsp_solution_value(rsp_solution_value),
      .rsp_last_element(rsp_last_element), .rsp_converged(rsp_converged),
      .rsp_steps_used(rsp_steps_used),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // One solution element as the block should emit it.
   typedef struct {
      logic [3:0]     element_index;
      cgs_pkg::q_type solution_value;
      logic           last_element;
      logic           converged;
      logic [15:0]    steps_used;
   } element_type;

   element_type solution_queue[$];

   // Shadow of the matrix, the right-hand side and the three registers.
   cgs_pkg::q_type shadow_matrix[cgs_pkg::MAX_N][cgs_pkg::MAX_N];
   cgs_pkg::q_type shadow_rhs[cgs_pkg::MAX_N];
   logic [4:0]     shadow_size = 5'd16;
   logic [15:0]    shadow_max_iter = 16'd1000;
   logic [30:0]    shadow_tol = 31'd1;

   int  error_count = 0;
   // When set, neither side inserts random idle cycles.
   bit  steady = 1'b0;
   // Cycles for which the result side is forced to stall.
   int  hold_cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Generous ceiling: every solve in this run is kept to a handful of iterations.
   initial begin
      #40ms;
      $display("conjugate_gradient_solver: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- arithmetic

   function automatic cgs_pkg::q_type clamp32(input longint v);
      if (v > 64'sd2147483647) return cgs_pkg::Q_MAX;
      if (v < -64'sd2147483648) return cgs_pkg::Q_MIN;
      return cgs_pkg::q_type'(v);
   endfunction

   // Q16.16 product kept wide; an arithmetic shift rounds toward minus infinity.
   function automatic longint fix_mul(input cgs_pkg::q_type a, input cgs_pkg::q_type b);
      return (longint'(a) * longint'(b)) >>> 16;
   endfunction

   function automatic cgs_pkg::q_type fix_div(input cgs_pkg::q_type num,
                                              input cgs_pkg::q_type den);
      if (den == 0) begin
         if (num > 0) return cgs_pkg::Q_MAX;
         if (num < 0) return cgs_pkg::Q_MIN;
         return 0;
      end
      return clamp32((longint'(num) * 65536) / longint'(den));
   endfunction

   function automatic cgs_pkg::q_type fix_dot(input cgs_pkg::q_type a[cgs_pkg::MAX_N],
                                              input cgs_pkg::q_type b[cgs_pkg::MAX_N],
                                              input int n);
      longint acc;
      acc = 0;
      for (int i = 0; i < n; i++) acc += fix_mul(a[i], b[i]);
      return clamp32(acc);
   endfunction

   // Runs the whole conjugate-gradient solve on the shadow state and queues the N
   // solution elements it should produce.
   function automatic void predict_solution();
      cgs_pkg::q_type x[cgs_pkg::MAX_N], r[cgs_pkg::MAX_N], p[cgs_pkg::MAX_N];
      cgs_pkg::q_type z[cgs_pkg::MAX_N], row[cgs_pkg::MAX_N];
      cgs_pkg::q_type gamma, gamma_next, alpha, beta;
      int             n;
      int             steps;
      bit             conv;
      element_type    e;
      n = shadow_size;
      if (n < 1) n = 1;
      if (n > cgs_pkg::MAX_N) n = cgs_pkg::MAX_N;
      steps = 0;
      conv = 1'b0;
      for (int i = 0; i < cgs_pkg::MAX_N; i++) begin
         x[i] = 0;
         r[i] = (i < n) ? shadow_rhs[i] : 0;
         p[i] = r[i];
         z[i] = 0;
      end
      gamma = fix_dot(r, r, n);
      while (steps < shadow_max_iter) begin
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < cgs_pkg::MAX_N; j++) row[j] = shadow_matrix[i][j];
            z[i] = fix_dot(row, p, n);
         end
         alpha = fix_div(gamma, fix_dot(p, z, n));
         for (int i = 0; i < n; i++) begin
            x[i] = clamp32(longint'(x[i]) + fix_mul(alpha, p[i]));
            r[i] = clamp32(longint'(r[i]) - fix_mul(alpha, z[i]));
         end
         gamma_next = fix_dot(r, r, n);
         steps++;
         if (longint'(gamma_next) < longint'(shadow_tol)) begin
            conv = 1'b1;
            break;
         end
         beta = fix_div(gamma_next, gamma);
         for (int i = 0; i < n; i++) p[i] = clamp32(longint'(r[i]) + fix_mul(beta, p[i]));
         gamma = gamma_next;
      end
      for (int i = 0; i < n; i++) begin
         e.element_index  = 4'(i);
         e.solution_value = x[i];
         e.last_element   = (i == n - 1);
         e.converged      = conv;
         e.steps_used     = 16'(steps);
         solution_queue.push_back(e);
      end
   endfunction

   // ---------------------------------------------------------------- driving

   // Sends one request beat, with random idle cycles ahead of it unless steady.
   task automatic send_beat(input logic [1:0] kind, input logic [3:0] row,
                            input logic [3:0] col, input cgs_pkg::q_type val);
      if (!steady) begin
         while ($urandom_range(99) < 32) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_row_index = row;
      req_col_index = col;
      req_value = val;
      do @(posedge clock); while (req_stall);
      // The beat was taken at this edge, so the shadow state moves with it.
      case (kind)
         cgs_pkg::KIND_LOAD_A: shadow_matrix[row][col] = val;
         cgs_pkg::KIND_LOAD_B: shadow_rhs[row] = val;
         cgs_pkg::KIND_START:  predict_solution();
         default: ;
      endcase
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Waits until every queued element has come back, then lets the block settle.
   task automatic wait_idle();
      while (solution_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Register writes only happen while the block is idle.
   task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {index, 2'b00};
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (index)
         cgs_pkg::REG_SIZE:     shadow_size = data[4:0];
         cgs_pkg::REG_MAX_ITER: shadow_max_iter = data[15:0];
         cgs_pkg::REG_TOL:      shadow_tol = data[30:0];
         default: ;
      endcase
   endtask

   task automatic set_solver(input int size, input int iters, input logic [31:0] tol);
      wait_idle();
      write_reg(cgs_pkg::REG_SIZE, 32'(size));
      write_reg(cgs_pkg::REG_MAX_ITER, 32'(iters));
      write_reg(cgs_pkg::REG_TOL, tol);
   endtask

   // A small value around zero, mostly within +/-2.0, now and then a full-range one.
   function automatic cgs_pkg::q_type rand_value();
      if ($urandom_range(9) == 0) return cgs_pkg::q_type'($urandom);
      return cgs_pkg::q_type'(int'($urandom_range(32'h3FFFF)) - 32'h20000);
   endfunction

   // The result side: random or forced stalls, changed at the falling edge.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 32);
      end
   end

   // Every accepted result beat is checked against the oldest expected element.
   always @(posedge clock) begin
      element_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (solution_queue.size() == 0) begin
            $error("unexpected result beat, element_index %0d", rsp_element_index);
            error_count++;
         end else begin
            e = solution_queue.pop_front();
            if (rsp_element_index !== e.element_index) begin
               $error("element_index expected %0d actual %0d", e.element_index,
                      rsp_element_index);
               error_count++;
            end
            if (rsp_solution_value !== e.solution_value) begin
               $error("solution_value expected %0d actual %0d", e.solution_value,
                      rsp_solution_value);
               error_count++;
            end
            if (rsp_last_element !== e.last_element) begin
               $error("last_element expected %0d actual %0d", e.last_element,
                      rsp_last_element);
               error_count++;
            end
            if (rsp_converged !== e.converged) begin
               $error("converged expected %0d actual %0d", e.converged, rsp_converged);
               error_count++;
            end
            if (rsp_steps_used !== e.steps_used) begin
               $error("steps_used expected %0d actual %0d", e.steps_used, rsp_steps_used);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Every matrix and right-hand-side entry is written once before any solve, so the
   // block never reads an entry that holds nothing. The matrix is made diagonally
   // heavy, which keeps the method well behaved.
   task automatic test_fill_system();
      set_solver(16, 2, 32'd1);
      for (int i = 0; i < cgs_pkg::MAX_N; i++) begin
         for (int j = 0; j < cgs_pkg::MAX_N; j++) begin
            send_beat(cgs_pkg::KIND_LOAD_A, 4'(i), 4'(j),
                      (i == j) ? cgs_pkg::q_type'(32'h40000 + $urandom_range(32'h3FFFF))
                               : cgs_pkg::q_type'(int'($urandom_range(32'hFFFF)) - 32'h8000));
         end
         send_beat(cgs_pkg::KIND_LOAD_B, 4'(i), 4'd0, rand_value());
      end
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
   endtask

   // Register extremes, the zero divisor and field extremes, with no idling on either side.
   task automatic test_corner_cases();
      steady = 1'b1;
      // A zero iteration limit must return x = 0 right away.
      set_solver(1, 0, 32'd0);
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      // The largest limit with the loosest tolerance: a 2.0 x = 1.0 system is solved
      // exactly in one step.
      set_solver(1, 65535, 32'h7FFFFFFF);
      send_beat(cgs_pkg::KIND_LOAD_A, 4'd0, 4'd0, cgs_pkg::q_type'(32'h20000));
      send_beat(cgs_pkg::KIND_LOAD_B, 4'd0, 4'd0, cgs_pkg::q_type'(32'h10000));
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      // A size of zero acts as one; sizes above the maximum act as the maximum.
      set_solver(0, 3, 32'd0);
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      set_solver(31, 1, 32'd0);
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      set_solver(17, 1, 32'd1000);
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      // Field extremes; the unused kind must leave everything alone.
      send_beat(cgs_pkg::KIND_LOAD_A, 4'd15, 4'd15, cgs_pkg::Q_MAX);
      send_beat(cgs_pkg::KIND_LOAD_A, 4'd0, 4'd15, cgs_pkg::Q_MIN);
      send_beat(cgs_pkg::KIND_LOAD_B, 4'd15, 4'd15, cgs_pkg::Q_MIN);
      send_beat(KIND_UNUSED, 4'd15, 4'd15, cgs_pkg::Q_MAX);
      set_solver(2, 2, 32'd0);
      send_beat(cgs_pkg::KIND_LOAD_B, 4'd0, 4'd0, cgs_pkg::Q_MAX);
      send_beat(cgs_pkg::KIND_LOAD_B, 4'd1, 4'd0, cgs_pkg::Q_MIN);
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      // A zero matrix makes p.z zero, so alpha saturates on a nonzero residual.
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) send_beat(cgs_pkg::KIND_LOAD_A, 4'(i), 4'(j), 0);
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      // An all-zero right-hand side gives a zero over zero quotient.
      send_beat(cgs_pkg::KIND_LOAD_B, 4'd0, 4'd0, 0);
      send_beat(cgs_pkg::KIND_LOAD_B, 4'd1, 4'd0, 0);
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      wait_idle();
      steady = 1'b0;
   endtask

   // The result side holds off for a long stretch while more loads are offered, so the
   // block, still busy with its solve, stalls its request side; then the sender waits for it all.
   task automatic test_backpressure();
      set_solver(4, 1, 32'd0);
      for (int i = 0; i < 4; i++)
         send_beat(cgs_pkg::KIND_LOAD_A, 4'(i), 4'(i), cgs_pkg::q_type'(32'h20000));
      hold_cycles = 3000;
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      for (int i = 0; i < 6; i++)
         send_beat(cgs_pkg::KIND_LOAD_B, 4'($urandom_range(3)), 4'($urandom), rand_value());
      send_beat(cgs_pkg::KIND_START, 4'd0, 4'd0, 0);
      wait_idle();
   endtask

   // Mostly loads with random content, each solve after a fresh register setting.
   // Sizes lean small and iteration limits stay low to bound the run time.
   task automatic test_random_traffic();
      int roll;
      for (int k = 0; k < 110; k++) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            set_solver(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 6),
                       $urandom_range(4),
                       ($urandom_range(1) == 0) ? $urandom_range(32'hFFFF) : $urandom);
            send_beat(cgs_pkg::KIND_START, 4'($urandom), 4'($urandom),
                      cgs_pkg::q_type'($urandom));
         end else if (roll < 60) begin
            send_beat(cgs_pkg::KIND_LOAD_A, 4'($urandom), 4'($urandom), rand_value());
         end else if (roll < 95) begin
            send_beat(cgs_pkg::KIND_LOAD_B, 4'($urandom), 4'($urandom), rand_value());
         end else begin
            send_beat(KIND_UNUSED, 4'($urandom), 4'($urandom), cgs_pkg::q_type'($urandom));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_fill_system();
      test_corner_cases();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (200) @(negedge clock);
      if (error_count == 0 && solution_queue.size() == 0) begin
         $display("conjugate_gradient_solver: match");
      end else begin
         $display("conjugate_gradient_solver: mismatch");
      end
      $finish;
   end

endmodule

// ===== conjugate_gradient_solver.f =====
hdl/cgs_pkg.sv
hdl/cgs_cell.sv
hdl/cgs_mul.sv
hdl/cgs_div.sv
hdl/conjugate_gradient_solver.sv
hdl/cgs_checker.sv
tb/tb_conjugate_gradient_solver.sv
